// ----- rtl/bdtb_pkg.sv -----
// Package: shared constants, register codes and types of the two's complement byte exporter
`timescale 1ns / 1ps
package bdtb_pkg;

  // Digit and byte geometry
  localparam int DIGIT_FIELD_W = 60;             // width of the digit port
  localparam int DIGIT_BITS    = 60;             // digit bits that count (8..60)
  localparam int MAX_BYTES     = 4096;           // upper bound on the byte count
  localparam int BYTE_W        = 8;
  localparam int CNT_W         = 13;             // byte_count register width
  localparam int POS_W         = 12;             // byte_position width
  localparam int CACHE_W       = BYTE_W - 1;     // leftover bits never reach a byte
  localparam int FILL_W        = $clog2(BYTE_W);
  localparam int CW            = DIGIT_BITS + CACHE_W;    // combined word width
  localparam int MAX_N         = CW / BYTE_W;             // bytes per digit, at most
  localparam int N_W           = $clog2(MAX_N + 1);
  localparam int TOTAL_W       = $clog2(CW + 1);

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QLVL_W = $clog2(QDEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN = CFG_IDX_W'(1);
  localparam logic [CNT_W-1:0]     BYTE_COUNT_RESET = CNT_W'(32);

  // One queued request: the bits to drain, how many bytes, first byte index
  typedef struct packed {
    logic [CW-1:0]    bits;
    logic [N_W-1:0]   n;
    logic [CNT_W-1:0] start;
  } q_entry_t;

  typedef struct packed {
    logic [QLVL_W-1:0] level;
    logic              full;
    logic              empty;
  } q_status_t;

  typedef struct packed {
    logic busy;
  } back_status_t;

endpackage

// ----- rtl/bigint_digits_to_twos_bytes.sv -----
// Top level: signed big integer digits to two's complement bytes with buffer positions
//
//   Channel  Direction  Handshake              Contents
//   in       sink       in_valid_i/in_stall_o  digit_value, negative, first_digit
//   out      source     out_valid_o/out_stall_i out_byte, byte_position, final_byte
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index (0 byte_count, 1 big_endian), data
//
// A digit request is taken whenever the two-entry queue has room; the
// front end resolves carry, bit packing and byte count on the spot.
// The back end emits one byte per cycle while out_stall_i is low, and a digit yields
// at most 8 bytes at the output port; the output register sets that rate.
// Reset clears carry to one, empties cache, counters, queue and output register,
// and loads byte_count = 32, big_endian = 0. No clearing pass is needed.
// out_stall_i holds the output register; the queue fills and then in_stall_o rises.
`timescale 1ns / 1ps
module bigint_digits_to_twos_bytes import bdtb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [DIGIT_FIELD_W-1:0] digit_value_i,
  input  logic                     negative_i,
  input  logic                     first_digit_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [BYTE_W-1:0]        out_byte_o,
  output logic [POS_W-1:0]         byte_position_o,
  output logic                     final_byte_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  logic [CNT_W-1:0] byte_count_q;
  logic             big_endian_q;
  logic [CNT_W-1:0] count;

  logic             push;
  logic             pop;
  q_entry_t         entry;
  q_entry_t         head;
  q_status_t        q_stat;
  back_status_t     back_stat;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= BYTE_COUNT_RESET;
      big_endian_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BYTE_COUNT: byte_count_q <= cfg_data_i[CNT_W-1:0];
        REG_BIG_ENDIAN: big_endian_q <= cfg_data_i[0];
        default:        byte_count_q <= byte_count_q;
      endcase
    end
  end

  // Clamp the byte count to the buffer size.
  assign count = (32'(byte_count_q) > MAX_BYTES) ? CNT_W'(MAX_BYTES) : byte_count_q;

  bdtb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .digit_value_i (digit_value_i),
    .negative_i    (negative_i),
    .first_digit_i (first_digit_i),
    .count_i       (count),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .entry_o       (entry)
  );

  bdtb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (q_stat)
  );

  bdtb_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .q_stat_i        (q_stat),
    .pop_o           (pop),
    .count_i         (count),
    .big_endian_i    (big_endian_q),
    .stat_o          (back_stat),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .byte_position_o (byte_position_o),
    .final_byte_o    (final_byte_o)
  );

  // Queue never overfills.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.level <= QLVL_W'(QDEPTH))
    else $error("request queue level beyond depth");

  // A push without a pop grows the queue by one.
  a_queue_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> q_stat.level == $past(q_stat.level) + QLVL_W'(1))
    else $error("request queue lost a push");

  // With nothing left to drain, the output goes quiet after its byte is taken.
  a_drain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !back_stat.busy && q_stat.empty |=> !out_valid_o)
    else $error("byte emitted with no request pending");

endmodule

// ----- rtl/bdtb_front.sv -----
// Front end: takes digits, forms two's complement, packs bits and queues byte runs
`timescale 1ns / 1ps
module bdtb_front import bdtb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [DIGIT_FIELD_W-1:0] digit_value_i,
  input  logic                     negative_i,
  input  logic                     first_digit_i,
  input  logic [CNT_W-1:0]         count_i,
  input  q_status_t                q_stat_i,
  output logic                     push_o,
  output q_entry_t                 entry_o
);

  logic                  carry_q;
  logic [CACHE_W-1:0]    cache_q;
  logic [FILL_W-1:0]     fill_q;
  logic [CNT_W-1:0]      done_q;

  logic                  base_carry;
  logic [CACHE_W-1:0]    base_cache;
  logic [FILL_W-1:0]     base_fill;
  logic [CNT_W-1:0]      base_done;
  logic                  accept;
  logic                  active;
  logic [DIGIT_BITS-1:0] d;
  logic [DIGIT_BITS:0]   ac;
  logic [DIGIT_BITS-1:0] x;
  logic [CW-1:0]         comb;
  logic [CW-1:0]         rest;
  logic [TOTAL_W-1:0]    total;
  logic [N_W-1:0]        avail;
  logic [CNT_W-1:0]      remain;
  logic [N_W-1:0]        n;
  logic [CNT_W-1:0]      done_n;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  always_comb begin
    // a new number starts from a clean slate
    base_carry = first_digit_i ? 1'b1 : carry_q;
    base_cache = first_digit_i ? '0 : cache_q;
    base_fill  = first_digit_i ? '0 : fill_q;
    base_done  = first_digit_i ? '0 : done_q;
    active     = base_done < count_i;

    d  = digit_value_i[DIGIT_BITS-1:0];
    ac = {1'b0, ~d} + (DIGIT_BITS + 1)'(base_carry);
    x  = negative_i ? ac[DIGIT_BITS-1:0] : d;

    comb   = (CW'(x) << base_fill) | CW'(base_cache);
    total  = TOTAL_W'(base_fill) + TOTAL_W'(DIGIT_BITS);
    avail  = N_W'(total >> FILL_W);
    remain = count_i - base_done;
    n      = (remain < CNT_W'(avail)) ? N_W'(remain) : avail;
    done_n = base_done + CNT_W'(n);
    rest   = comb >> (n * BYTE_W);
  end

  assign push_o        = accept && active;
  assign entry_o.bits  = comb;
  assign entry_o.n     = n;
  assign entry_o.start = base_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= 1'b1;
      cache_q <= '0;
      fill_q  <= '0;
      done_q  <= '0;
    end else if (accept) begin
      carry_q <= (active && negative_i) ? ac[DIGIT_BITS] : base_carry;
      if (!active) begin
        cache_q <= base_cache;
        fill_q  <= base_fill;
        done_q  <= base_done;
      end else if (done_n >= count_i) begin
        // number complete: drop leftover bits
        cache_q <= '0;
        fill_q  <= '0;
        done_q  <= done_n;
      end else begin
        cache_q <= rest[CACHE_W-1:0];
        fill_q  <= total[FILL_W-1:0];
        done_q  <= done_n;
      end
    end
  end

endmodule

// ----- rtl/bdtb_queue.sv -----
// Short request queue between the front and back ends
`timescale 1ns / 1ps
module bdtb_queue import bdtb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  q_entry_t  entry_i,
  input  logic      pop_i,
  output q_entry_t  head_o,
  output q_status_t stat_o
);

  q_entry_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QLVL_W-1:0] level_q;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.level = level_q;
  assign stat_o.full  = level_q == QLVL_W'(QDEPTH);
  assign stat_o.empty = level_q == '0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   level_q <= level_q + QLVL_W'(1);
        2'b01:   level_q <= level_q - QLVL_W'(1);
        default: level_q <= level_q;
      endcase
    end
  end

endmodule

// ----- rtl/bdtb_back.sv -----
// Back end: drains queued byte runs one byte a cycle, unless stalled, into the output register
`timescale 1ns / 1ps
module bdtb_back import bdtb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  q_entry_t           head_i,
  input  q_status_t          q_stat_i,
  output logic               pop_o,
  input  logic [CNT_W-1:0]   count_i,
  input  logic               big_endian_i,
  output back_status_t       stat_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [BYTE_W-1:0]  out_byte_o,
  output logic [POS_W-1:0]   byte_position_o,
  output logic               final_byte_o
);

  logic [CW-1:0]     word_q;
  logic [N_W-1:0]    rem_q;
  logic [CNT_W-1:0]  idx_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic [POS_W-1:0]  pos_q;
  logic              final_q;

  logic              adv;
  logic              emit;
  logic              load;
  logic [CNT_W-1:0]  mirrored;

  assign adv      = !out_valid_q || !out_stall_i;
  assign emit     = adv && (rem_q != '0);
  // refill as the last byte of the current run leaves
  assign load     = !q_stat_i.empty && ((rem_q == '0) || (emit && rem_q == N_W'(1)));
  assign pop_o    = load;
  assign mirrored = count_i - CNT_W'(1) - idx_q;

  assign stat_o.busy     = rem_q != '0;
  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign byte_position_o = pos_q;
  assign final_byte_o    = final_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        rem_q <= head_i.n;
        idx_q <= head_i.start;
      end else if (emit) begin
        rem_q <= rem_q - N_W'(1);
        idx_q <= idx_q + CNT_W'(1);
      end
      if (adv) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= head_i.bits;
    end else if (emit) begin
      word_q <= word_q >> BYTE_W;
    end
    if (emit) begin
      out_byte_q <= word_q[BYTE_W-1:0];
      pos_q      <= big_endian_i ? mirrored[POS_W-1:0] : idx_q[POS_W-1:0];
      final_q    <= (idx_q + CNT_W'(1)) == count_i;
    end
  end

endmodule

// ----- tb/tb.sv -----
// Testbench for the two's complement byte exporter: directed and random digit streams
`timescale 1ns / 1ps
module tb import bdtb_pkg::*; ();

  // Share of cycles in which each side idles while idling is on
  localparam int IDLE_PCT     = 34;
  // Cycles to let pass once nothing is expected: queue, back end and output register
  localparam int DRAIN_CYCLES = 40;
  // Length of the long receiver hold-off
  localparam int HOLD_LEN     = 300;
  // Upper bound on the run length; keep a wide margin
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_PRINTS   = 40;
  // Index outside the register map: a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(15);
  localparam logic [DIGIT_FIELD_W-1:0] DIGIT_ONES = '1;

  // One expected byte at the output port
  typedef struct {
    logic [BYTE_W-1:0] value;
    logic [POS_W-1:0]  pos;
    logic              last;
  } export_byte_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [DIGIT_FIELD_W-1:0] digit_value_i = '0;
  logic                     negative_i = 1'b0;
  logic                     first_digit_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [BYTE_W-1:0]        out_byte_o;
  logic [POS_W-1:0]         byte_position_o;
  logic                     final_byte_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i = '0;

  bigint_digits_to_twos_bytes dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .digit_value_i  (digit_value_i),
    .negative_i     (negative_i),
    .first_digit_i  (first_digit_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .byte_position_o(byte_position_o),
    .final_byte_o   (final_byte_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: a private copy of the exporter's registers and number state
  logic             sign_carry = 1'b1;
  logic [63:0]      pending_bits = '0;
  int unsigned      pending_fill = 0;
  int unsigned      bytes_emitted = 0;
  logic [CNT_W-1:0] cfg_count = BYTE_COUNT_RESET;
  logic             cfg_big_endian = 1'b0;

  export_byte_t expected_bytes[$];

  int unsigned mismatches = 0;
  int unsigned bytes_checked = 0;
  int unsigned digits_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned cycles = 0;
  int unsigned gap_pct = IDLE_PCT;
  int unsigned stall_pct = IDLE_PCT;

  // Hold-off handshake: the test flips hold_toggle, the stall driver counts the hold
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatches < MAX_PRINTS)
      $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Work out the bytes one accepted digit request yields and queue them
  task automatic predict_digit_bytes(input logic [DIGIT_FIELD_W-1:0] value, input logic neg,
                                     input logic first);
    logic [DIGIT_BITS-1:0] digit;
    logic [DIGIT_BITS:0]   sum;
    logic [DIGIT_BITS-1:0] bits;
    logic [71:0]           word;
    int unsigned           avail;
    int unsigned           count;
    export_byte_t          b;
    digit = value[DIGIT_BITS-1:0];
    if (first) begin
      sign_carry    = 1'b1;
      pending_bits  = '0;
      pending_fill  = 0;
      bytes_emitted = 0;
    end
    count = (cfg_count > MAX_BYTES) ? MAX_BYTES : cfg_count;
    // Number already complete (or count lowered below it): nothing moves
    if (bytes_emitted >= count) return;
    if (neg) begin
      sum        = {1'b0, ~digit} + (DIGIT_BITS+1)'(sign_carry);
      bits       = sum[DIGIT_BITS-1:0];
      sign_carry = sum[DIGIT_BITS];
    end else begin
      bits = digit;
    end
    pending_fill = pending_fill & 7;
    word  = {8'h00, pending_bits} | (72'(bits) << pending_fill);
    avail = pending_fill + DIGIT_BITS;
    while (avail >= 8 && bytes_emitted < count) begin
      b.value = word[7:0];
      b.pos   = POS_W'(cfg_big_endian ? (count - 1 - bytes_emitted) : bytes_emitted);
      b.last  = (bytes_emitted + 1 == count);
      expected_bytes.push_back(b);
      word = word >> 8;
      avail -= 8;
      bytes_emitted++;
    end
    // Completion drops leftover bits but keeps the carry
    if (bytes_emitted >= count) begin
      pending_bits = '0;
      pending_fill = 0;
    end else begin
      pending_bits = word[63:0];
      pending_fill = avail;
    end
  endtask

  // Offer one digit request, with a random gap ahead of it, and predict on acceptance
  task automatic send_digit(input logic [DIGIT_FIELD_W-1:0] value, input logic neg,
                            input logic first);
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    digit_value_i <= value;
    negative_i    <= neg;
    first_digit_i <= first;
    do @(posedge clk_i); while (in_stall_o);
    predict_digit_bytes(value, neg, first);
    digits_sent++;
  endtask

  // Drop valid, wait until every expected byte is out, then let the pipeline drain
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register write; only called while the exporter is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int unsigned data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= CFG_DATA_W'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (index == REG_BYTE_COUNT) cfg_count = CNT_W'(data);
    else if (index == REG_BIG_ENDIAN) cfg_big_endian = data[0];
    reg_writes++;
    // Idle so the next write starts on a later edge
    @(posedge clk_i);
  endtask

  function automatic logic [DIGIT_FIELD_W-1:0] random_digit();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DIGIT_ONES;
      2:       return DIGIT_FIELD_W'(1);
      default: return DIGIT_FIELD_W'({$urandom, $urandom});
    endcase
  endfunction

  // Mostly well-formed numbers: one sign, zeros past the magnitude; some noise
  task automatic send_random_number();
    int unsigned              len;
    int unsigned              mag;
    logic                     neg;
    logic                     dneg;
    logic                     dfirst;
    logic [DIGIT_FIELD_W-1:0] d;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3))
        send_digit(random_digit(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else begin
      len = $urandom_range(1, 6);
      mag = $urandom_range(1, len);
      neg = 1'($urandom_range(0, 1));
      for (int i = 0; i < len; i++) begin
        d      = (i < mag) ? random_digit() : '0;
        dneg   = ($urandom_range(0, 19) == 0) ? !neg : neg;
        dfirst = (i == 0) || ($urandom_range(0, 29) == 0);
        send_digit(d, dneg, dfirst);
      end
    end
  endtask

  // Reset values in force: 32 bytes, little-endian
  task automatic test_reset_defaults();
    // Positive number: completes on the fifth digit, the sixth is past completion
    send_digit(DIGIT_ONES, 1'b0, 1'b1);
    send_digit('0, 1'b0, 1'b0);
    send_digit(60'h123_4567_89AB_CDEF, 1'b0, 1'b0);
    send_digit(60'hF0F_0F0F_0F0F_0F0F, 1'b0, 1'b0);
    send_digit(DIGIT_ONES, 1'b0, 1'b0);
    send_digit(60'h1, 1'b0, 1'b0);
    // Negative zero low digit: carry runs through to the next digit
    send_digit('0, 1'b1, 1'b1);
    send_digit(60'h1, 1'b1, 1'b0);
    send_digit('0, 1'b1, 1'b0);
    // Sign flag changing between digits of one number
    send_digit(60'h5, 1'b1, 1'b1);
    send_digit(60'h5, 1'b0, 1'b0);
    send_digit(DIGIT_ONES, 1'b1, 1'b0);
    settle();
  endtask

  // Zero, raised, lowered, single and oversized byte counts; both byte orders
  task automatic test_byte_count_cases();
    // Zero byte count: nothing ever comes out
    write_reg(REG_BYTE_COUNT, 0);
    send_digit(DIGIT_ONES, 1'b1, 1'b1);
    send_digit(60'hABC, 1'b0, 1'b0);
    settle();
    // Count of three, big-endian: done after one digit, leftover bits dropped
    write_reg(REG_BYTE_COUNT, 3);
    write_reg(REG_BIG_ENDIAN, 1);
    send_digit(60'h0AB_CDEF_0123_4567, 1'b1, 1'b1);
    settle();
    // Raise the count mid-number: resume at byte three with an empty cache
    write_reg(REG_BYTE_COUNT, 20);
    send_digit(60'h765_4321_0FED_CBA9, 1'b1, 1'b0);
    settle();
    // Lower the count below the bytes already out: number counts as complete
    write_reg(REG_BYTE_COUNT, 5);
    send_digit(DIGIT_ONES, 1'b0, 1'b0);
    settle();
    write_reg(REG_BYTE_COUNT, 20);
    send_digit(60'h3C3_C3C3_C3C3_C3C3, 1'b0, 1'b0);
    settle();
    // Single byte, little-endian; a write to a spare index must change nothing
    write_reg(REG_BIG_ENDIAN, 0);
    write_reg(REG_BYTE_COUNT, 1);
    write_reg(REG_SPARE, 8191);
    send_digit(60'hAB, 1'b0, 1'b1);
    settle();
    // Count above the maximum acts as the maximum: positions from 4095 down
    write_reg(REG_BYTE_COUNT, 8191);
    write_reg(REG_BIG_ENDIAN, 1);
    send_digit(DIGIT_ONES, 1'b0, 1'b1);
    send_digit(60'h800_0000_0000_0001, 1'b1, 1'b0);
    settle();
    write_reg(REG_BYTE_COUNT, MAX_BYTES);
    send_digit(60'h55A_A55A_A55A_A55A, 1'b1, 1'b1);
    settle();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering requests
  task automatic test_output_hold_off();
    int unsigned start_count;
    write_reg(REG_BYTE_COUNT, 16);
    write_reg(REG_BIG_ENDIAN, 0);
    start_count = digits_sent;
    hold_toggle = !hold_toggle;
    while (digits_sent - start_count < 20) send_random_number();
    // Pause until every expected byte has come
    settle();
  endtask

  // Full rate on both sides: no gaps, no stalls
  task automatic test_back_to_back();
    int unsigned start_count;
    gap_pct   = 0;
    stall_pct = 0;
    write_reg(REG_BYTE_COUNT, 24);
    write_reg(REG_BIG_ENDIAN, 1);
    start_count = digits_sent;
    while (digits_sent - start_count < 40) send_random_number();
    settle();
    gap_pct   = IDLE_PCT;
    stall_pct = IDLE_PCT;
  endtask

  // Random settings in phases, random numbers within each phase
  task automatic test_random_numbers(input int unsigned target);
    int unsigned start_count;
    int unsigned count;
    start_count = digits_sent;
    while (digits_sent - start_count < target) begin
      case ($urandom_range(0, 7))
        0:       count = 1;
        1:       count = 2;
        2:       count = 7;
        3:       count = 8;
        4:       count = 9;
        5:       count = 64;
        default: count = $urandom_range(3, 120);
      endcase
      write_reg(REG_BYTE_COUNT, count);
      write_reg(REG_BIG_ENDIAN, $urandom_range(0, 1));
      repeat (8) send_random_number();
      settle();
    end
  endtask

  // Receiver side: a counted hold-off when asked, random stalls otherwise
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen   <= hold_toggle;
      hold_left   <= HOLD_LEN;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each accepted byte with the oldest expectation
  always @(posedge clk_i) begin : check_bytes
    export_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        report_mismatch("byte with nothing expected", out_byte_o, 0);
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte_o !== want.value) report_mismatch("out_byte", out_byte_o, want.value);
        if (byte_position_o !== want.pos)
          report_mismatch("byte_position", byte_position_o, want.pos);
        if (final_byte_o !== want.last)
          report_mismatch("final_byte", final_byte_o, want.last);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bytes still expected", cycles,
               expected_bytes.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    // Hold reset, then release at a rising edge
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_byte_count_cases();
    test_output_hold_off();
    test_back_to_back();
    test_random_numbers(280);

    settle();
    $display("Checked %0d bytes from %0d digit requests over %0d register writes,",
             bytes_checked, digits_sent, reg_writes);
    $display("with zero, single, raised, lowered and 4096-byte counts in both byte orders.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
